FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define CHK_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHK_ON(lbl, prop, msg)
`define CHK_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/tpss_pkg.sv
package tpss_pkg;

  localparam int NUM_LANES = 4;
  localparam int DIV_STEPS = 33;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [32:0] diff;
    logic signed [31:0] da;
    logic signed [32:0] den;
  } lane_t;

  // lanes in output order: start_x, start_y, end_x, end_y
  typedef struct packed {
    lane_t [NUM_LANES-1:0] lanes;
  } item_t;

  function automatic lane_t make_cross(input logic signed [31:0] a, input logic signed [31:0] b,
                                       input logic signed [31:0] da,
                                       input logic signed [31:0] db);
    lane_t l;
    l.a = a;
    l.diff = {b[31], b} - {a[31], a};
    l.da = da;
    l.den = {da[31], da} - {db[31], db};
    return l;
  endfunction

  // zero difference makes the quotient zero, so the lane returns a unchanged
  function automatic lane_t make_pass(input logic signed [31:0] a);
    lane_t l;
    l.a = a;
    l.diff = '0;
    l.da = '0;
    l.den = 33'sd1;
    return l;
  endfunction

  function automatic logic [1:0] lo_idx(input logic [2:0] m);
    logic [1:0] r;
    r = 2'd0;
    if (m[0]) r = 2'd0;
    else if (m[1]) r = 2'd1;
    else if (m[2]) r = 2'd2;
    return r;
  endfunction

  function automatic logic [1:0] hi_idx(input logic [2:0] m);
    logic [1:0] r;
    r = 2'd0;
    if (m[2]) r = 2'd2;
    else if (m[1]) r = 2'd1;
    else if (m[0]) r = 2'd0;
    return r;
  endfunction

endpackage

FILE: rtl/tpss_front.sv
module tpss_front
  import tpss_pkg::*;
(
  input  logic               in_valid,
  input  logic signed [31:0] dist_0,
  input  logic signed [31:0] dist_1,
  input  logic signed [31:0] dist_2,
  input  logic signed [31:0] px_0,
  input  logic signed [31:0] py_0,
  input  logic signed [31:0] px_1,
  input  logic signed [31:0] py_1,
  input  logic signed [31:0] px_2,
  input  logic signed [31:0] py_2,
  output logic               push_valid,
  output item_t              push_item
);

  logic signed [31:0] d [3];
  logic signed [31:0] x [3];
  logic signed [31:0] y [3];
  logic [2:0] pos, neg, zer;
  logic [1:0] non, nup;
  logic [1:0] i0, i1, i2, s;
  logic [2:0] others;
  logic has_result;

  assign d[0] = dist_0;
  assign d[1] = dist_1;
  assign d[2] = dist_2;
  assign x[0] = px_0;
  assign x[1] = px_1;
  assign x[2] = px_2;
  assign y[0] = py_0;
  assign y[1] = py_1;
  assign y[2] = py_2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos[i] = !d[i][31] && (d[i] != '0);
      neg[i] = d[i][31];
      zer[i] = (d[i] == '0);
    end
    non = 2'(zer[0]) + 2'(zer[1]) + 2'(zer[2]);
    nup = 2'(pos[0]) + 2'(pos[1]) + 2'(pos[2]);
    s = (nup == 2'd1) ? lo_idx(pos) : lo_idx(neg);
    others = ~(3'b001 << s);
    i0 = 2'd0;
    i1 = 2'd0;
    i2 = 2'd0;
    has_result = 1'b0;
    push_item = '0;
    if (non == 2'd2) begin
      has_result = 1'b1;
      i0 = lo_idx(zer);
      i1 = hi_idx(zer);
      push_item.lanes[0] = make_pass(x[i0]);
      push_item.lanes[1] = make_pass(y[i0]);
      push_item.lanes[2] = make_pass(x[i1]);
      push_item.lanes[3] = make_pass(y[i1]);
    end else if ((pos != '0) && (neg != '0)) begin
      has_result = 1'b1;
      if (non == 2'd1) begin
        i0 = lo_idx(zer);
        i1 = lo_idx(pos);
        i2 = lo_idx(neg);
        push_item.lanes[0] = make_pass(x[i0]);
        push_item.lanes[1] = make_pass(y[i0]);
        push_item.lanes[2] = make_cross(x[i1], x[i2], d[i1], d[i2]);
        push_item.lanes[3] = make_cross(y[i1], y[i2], d[i1], d[i2]);
      end else begin
        // lone vertex against the other two, in vertex order
        i1 = lo_idx(others);
        i2 = hi_idx(others);
        push_item.lanes[0] = make_cross(x[s], x[i1], d[s], d[i1]);
        push_item.lanes[1] = make_cross(y[s], y[i1], d[s], d[i1]);
        push_item.lanes[2] = make_cross(x[s], x[i2], d[s], d[i2]);
        push_item.lanes[3] = make_cross(y[s], y[i2], d[s], d[i2]);
      end
    end
  end

  assign push_valid = in_valid && has_result;

endmodule

FILE: rtl/tpss_fifo.sv
`include "assert_macros.svh"

module tpss_fifo
  import tpss_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_stall,
  output logic  out_valid,
  output item_t out_item,
  input  logic  out_stall
);

  item_t mem [QUEUE_DEPTH];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop;

  assign in_stall = (count == 2'(QUEUE_DEPTH));
  assign out_valid = (count != 2'd0);
  assign out_item = mem[rd_ptr];
  assign push = in_valid && !in_stall;
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `CHK_ON(a_count_range, count <= 2'(QUEUE_DEPTH), "queue count out of range")
  `CHK_ON(a_ptr_gap, (count == 2'd1) |-> (wr_ptr != rd_ptr), "queue pointers disagree with count")
  `CHK_ALWAYS(a_reset_empty, rst |=> (count == 2'd0), "queue not empty after reset")

endmodule

FILE: rtl/tpss_back.sv
`include "assert_macros.svh"

module tpss_back
  import tpss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  item_t              in_item,
  output logic               in_stall,
  output logic               out_valid,
  output logic signed [31:0] start_x,
  output logic signed [31:0] start_y,
  output logic signed [31:0] end_x,
  output logic signed [31:0] end_y,
  input  logic               out_stall
);

  logic adv;

  // entry: magnitudes and result sign
  logic        s0_v;
  logic [32:0] s0_dif [NUM_LANES];
  logic [31:0] s0_da  [NUM_LANES];
  logic [32:0] s0_den [NUM_LANES];
  logic        s0_neg [NUM_LANES];
  logic signed [31:0] s0_a [NUM_LANES];

  // split product, two 33x16 halves
  logic        s1_v;
  logic [48:0] s1_lo  [NUM_LANES];
  logic [48:0] s1_hi  [NUM_LANES];
  logic [32:0] s1_den [NUM_LANES];
  logic        s1_neg [NUM_LANES];
  logic signed [31:0] s1_a [NUM_LANES];

  logic        s2_v;
  logic [63:0] s2_num [NUM_LANES];
  logic [32:0] s2_den [NUM_LANES];
  logic        s2_neg [NUM_LANES];
  logic signed [31:0] s2_a [NUM_LANES];

  // one quotient bit per stage
  logic        dv_v   [DIV_STEPS];
  logic [32:0] dv_rem [DIV_STEPS][NUM_LANES];
  logic [32:0] dv_acc [DIV_STEPS][NUM_LANES];
  logic [32:0] dv_den [DIV_STEPS][NUM_LANES];
  logic        dv_neg [DIV_STEPS][NUM_LANES];
  logic signed [31:0] dv_a [DIV_STEPS][NUM_LANES];

  logic signed [31:0] res [NUM_LANES];

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        s0_dif[l] <= in_item.lanes[l].diff[32] ? 33'(-in_item.lanes[l].diff)
                                               : 33'(in_item.lanes[l].diff);
        s0_da[l]  <= in_item.lanes[l].da[31] ? 32'(-in_item.lanes[l].da)
                                             : 32'(in_item.lanes[l].da);
        s0_den[l] <= in_item.lanes[l].den[32] ? 33'(-in_item.lanes[l].den)
                                              : 33'(in_item.lanes[l].den);
        s0_neg[l] <= in_item.lanes[l].diff[32] ^ in_item.lanes[l].da[31]
                     ^ in_item.lanes[l].den[32];
        s0_a[l]   <= in_item.lanes[l].a;
        s1_lo[l]  <= 49'(s0_dif[l]) * 49'(s0_da[l][15:0]);
        s1_hi[l]  <= 49'(s0_dif[l]) * 49'(s0_da[l][31:16]);
        s1_den[l] <= s0_den[l];
        s1_neg[l] <= s0_neg[l];
        s1_a[l]   <= s0_a[l];
        s2_num[l] <= 64'(s1_lo[l]) + (64'(s1_hi[l]) << 16);
        s2_den[l] <= s1_den[l];
        s2_neg[l] <= s1_neg[l];
        s2_a[l]   <= s1_a[l];
      end
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [32:0] p_rem, p_acc, p_den;
      logic        p_neg;
      logic signed [31:0] p_a;
      logic [33:0] trial;
      logic        ge;

      if (j == 0) begin : g_first
        // quotient fits 33 bits, so the top of the numerator is already below the divisor
        assign p_rem = {2'b00, s2_num[l][63:33]};
        assign p_acc = s2_num[l][32:0];
        assign p_den = s2_den[l];
        assign p_neg = s2_neg[l];
        assign p_a   = s2_a[l];
      end else begin : g_next
        assign p_rem = dv_rem[j-1][l];
        assign p_acc = dv_acc[j-1][l];
        assign p_den = dv_den[j-1][l];
        assign p_neg = dv_neg[j-1][l];
        assign p_a   = dv_a[j-1][l];
      end

      assign trial = {p_rem, p_acc[32]};
      assign ge = (trial >= {1'b0, p_den});

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem[j][l] <= ge ? 33'(trial - {1'b0, p_den}) : trial[32:0];
          dv_acc[j][l] <= {p_acc[31:0], ge};
          dv_den[j][l] <= p_den;
          dv_neg[j][l] <= p_neg;
          dv_a[j][l]   <= p_a;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j] <= 1'b0;
      end else if (adv) begin
        dv_v[j] <= (j == 0) ? s2_v : dv_v[(j == 0) ? 0 : j-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      res[l] = 32'(34'({dv_a[DIV_STEPS-1][l][31], dv_a[DIV_STEPS-1][l]})
               + (dv_neg[DIV_STEPS-1][l] ? 34'(-{1'b0, dv_acc[DIV_STEPS-1][l]})
                                         : 34'({1'b0, dv_acc[DIV_STEPS-1][l]})));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s0_v <= in_valid;
      s1_v <= s0_v;
      s2_v <= s1_v;
      out_valid <= dv_v[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      start_x <= res[0];
      start_y <= res[1];
      end_x   <= res[2];
      end_y   <= res[3];
    end
  end

  `CHK_ON(a_freeze, (out_valid && out_stall) |=> $stable(dv_v[DIV_STEPS-1]), "pipe moved under stall")
  `CHK_ON(a_no_take, (out_valid && out_stall) |-> in_stall, "queue popped while pipe frozen")
  `CHK_ALWAYS(a_reset_clear, rst |=> (!out_valid && !s0_v), "pipe valid after reset")

endmodule

FILE: rtl/triangle_plane_slice_segment_unit.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   dist_0..2, px_0..2, py_0..2
// out       output     out_valid / out_stall start_x, start_y, end_x, end_y
//
// one triangle per cycle, unless a stalled output has filled the queue
// the pipe is a 33-step bit-per-stage divider behind a split multiplier
// triangles with no segment are dropped at the front and take no pipe slot
// synchronous reset clears the queue and every pipe valid
// a stalled output freezes the pipe; the 2-entry queue keeps taking input until full
module triangle_plane_slice_segment_unit
  import tpss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] dist_0,
  input  logic signed [31:0] dist_1,
  input  logic signed [31:0] dist_2,
  input  logic signed [31:0] px_0,
  input  logic signed [31:0] py_0,
  input  logic signed [31:0] px_1,
  input  logic signed [31:0] py_1,
  input  logic signed [31:0] px_2,
  input  logic signed [31:0] py_2,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] start_x,
  output logic signed [31:0] start_y,
  output logic signed [31:0] end_x,
  output logic signed [31:0] end_y
);

  logic  push_valid;
  item_t push_item;
  logic  q_valid, q_stall;
  item_t q_item;

  tpss_front u_front (
    .in_valid   (in_valid),
    .dist_0     (dist_0),
    .dist_1     (dist_1),
    .dist_2     (dist_2),
    .px_0       (px_0),
    .py_0       (py_0),
    .px_1       (px_1),
    .py_1       (py_1),
    .px_2       (px_2),
    .py_2       (py_2),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  tpss_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_item   (push_item),
    .in_stall  (in_stall),
    .out_valid (q_valid),
    .out_item  (q_item),
    .out_stall (q_stall)
  );

  tpss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .in_stall  (q_stall),
    .out_valid (out_valid),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_stall (out_stall)
  );

endmodule
